// File: rtl/fat12cte_pkg.sv
// ----------------------------------------------------------------------------
// FAT12 cluster table engine package
// Shared types, register map, request codes and row helpers for the engine.
// ----------------------------------------------------------------------------
package fat12cte_pkg;

    // One memory row holds two packed 12-bit entries (three image bytes).
    localparam int ROW_BITS    = 24;
    localparam int ENTRY_W     = 12;
    localparam int BOFF_W      = 13;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    // Reciprocal of three, scaled by 2^13; exact for every 13-bit offset.
    localparam logic [11:0] DIV3_MUL   = 12'd2731;
    localparam int          DIV3_SHIFT = 13;

    localparam logic [11:0] EOC_MARK = 12'hFFF;
    localparam logic [11:0] EOC_MIN  = 12'hFF8;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_SPC          = 2'd0;
    localparam logic [1:0] REG_DATA_START   = 2'd1;
    localparam logic [1:0] REG_SEARCH_START = 2'd2;

    localparam logic [7:0]  SPC_RESET          = 8'd1;
    localparam logic [31:0] DATA_START_RESET   = 32'd0;
    localparam logic [11:0] SEARCH_START_RESET = 12'd3;

    typedef enum logic [2:0] {
        REQ_READ_ENTRY  = 3'd0,
        REQ_WRITE_ENTRY = 3'd1,
        REQ_ALLOC       = 3'd2,
        REQ_WRITE_BYTE  = 3'd3,
        REQ_READ_BYTE   = 3'd4
    } req_type_t;

    typedef enum logic [2:0] {
        ST_CLEAR   = 3'd0,
        ST_IDLE    = 3'd1,
        ST_EXEC    = 3'd2,
        ST_LINK_RD = 3'd3,
        ST_LINK_WR = 3'd4
    } state_t;

    typedef struct packed {
        logic [7:0]  sec_per_clus;
        logic [31:0] data_area_start;
        logic [11:0] search_start;
    } cfg_t;

    typedef struct packed {
        logic [11:0] result_cluster;
        logic [11:0] result_value;
        logic [31:0] first_sector;
        logic        end_of_chain;
        logic        status;
    } result_t;

    // Even clusters sit in the low half of a row, odd clusters in the high half.
    function automatic logic [ENTRY_W-1:0] entry_of(input logic [ROW_BITS-1:0] row,
                                                    input logic odd);
        return odd ? row[23:12] : row[11:0];
    endfunction

    function automatic logic [ROW_BITS-1:0] row_with_entry(input logic [ROW_BITS-1:0] row,
                                                           input logic odd,
                                                           input logic [ENTRY_W-1:0] v);
        return odd ? {v, row[11:0]} : {row[23:12], v};
    endfunction

endpackage

// File: rtl/fat12cte_ram.sv
// ----------------------------------------------------------------------------
// FAT12 table row memory
// Single-port synchronous RAM with registered read data, held until the
// next read.
// ----------------------------------------------------------------------------
module fat12cte_ram #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  logic                                aclk,
    input  logic                                en,
    input  logic                                we,
    input  logic [ADDR_W-1:0]                   addr,
    input  logic [fat12cte_pkg::ROW_BITS-1:0]   wdata,
    output logic [fat12cte_pkg::ROW_BITS-1:0]   rdata
);
    import fat12cte_pkg::*;

    logic [ROW_BITS-1:0] mem [DEPTH];
    logic [ROW_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/fat12cte_regs.sv
// ----------------------------------------------------------------------------
// FAT12 engine configuration registers
// APB-style register file for sector mapping and the allocation search start.
// ----------------------------------------------------------------------------
module fat12cte_regs (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [fat12cte_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [fat12cte_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [fat12cte_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output fat12cte_pkg::cfg_t                    cfg
);
    import fat12cte_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_index;
    logic       wr_en;

    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_index)
                REG_SPC:          cfg_next.sec_per_clus    = pwdata[7:0];
                REG_DATA_START:   cfg_next.data_area_start = pwdata;
                REG_SEARCH_START: cfg_next.search_start    = pwdata[11:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sec_per_clus    <= SPC_RESET;
            cfg_reg.data_area_start <= DATA_START_RESET;
            cfg_reg.search_start    <= SEARCH_START_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_index)
            REG_SPC:          prdata = {24'd0, cfg_reg.sec_per_clus};
            REG_DATA_START:   prdata = cfg_reg.data_area_start;
            REG_SEARCH_START: prdata = {20'd0, cfg_reg.search_start};
            default:          prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/fat12cte_seq.sv
// ----------------------------------------------------------------------------
// FAT12 engine request sequencer
// Reads, modifies and writes back table rows, runs the free-cluster scan and
// holds the result register.
// ----------------------------------------------------------------------------
module fat12cte_seq #(
    parameter int NUM_CLUSTERS = 4096,
    parameter int ROWS         = 2048,
    parameter int ROW_W        = 11
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fat12cte_pkg::cfg_t                  cfg,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [2:0]                          req_type,
    input  logic [11:0]                         cluster,
    input  logic [11:0]                         entry_value,
    input  logic [11:0]                         chain_tail,
    input  logic [12:0]                         byte_offset,
    input  logic [7:0]                          byte_value,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output fat12cte_pkg::result_t               result,
    output logic                                mem_en,
    output logic                                mem_we,
    output logic [ROW_W-1:0]                    mem_addr,
    output logic [fat12cte_pkg::ROW_BITS-1:0]   mem_wdata,
    input  logic [fat12cte_pkg::ROW_BITS-1:0]   mem_rdata
);
    import fat12cte_pkg::*;

    localparam int          TABLE_BYTES = (3 * NUM_CLUSTERS + 1) / 2;
    localparam logic [12:0] NUM_CL      = 13'(NUM_CLUSTERS);
    localparam logic [13:0] NUM_BYTES   = 14'(TABLE_BYTES);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [2:0]        req_reg, req_next;
    logic [11:0]       cl_reg, cl_next;
    logic [11:0]       val_reg, val_next;
    logic [11:0]       prev_reg, prev_next;
    logic [ROW_W-1:0]  brow_reg, brow_next;
    logic [1:0]        blane_reg, blane_next;
    logic              bok_reg, bok_next;
    logic [7:0]        bval_reg, bval_next;
    logic [11:0]       scan_reg, scan_next;
    logic              m_valid_reg, m_valid_next;
    result_t           res_reg, res_next;

    logic              accept;
    logic              out_free;
    logic [24:0]       div_prod;
    logic [11:0]       in_q;
    logic [12:0]       in_rem;
    logic              in_cl_ok;
    logic              in_ss_ok;
    logic              in_b_ok;
    logic              cl_ok;
    logic              prev_ok;
    logic              scan_ok;
    logic              scan_inc_ok;
    logic [11:0]       scan_inc;
    logic [11:0]       cur_entry;
    logic [7:0]        cur_byte;
    logic [11:0]       sec_cl;
    logic [31:0]       sec_base;
    logic [31:0]       sector;

    function automatic logic [ROW_W-1:0] row_of(input logic [11:0] c);
        return ROW_W'(c[11:1]);
    endfunction

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Byte offset split into row and lane by a reciprocal multiply.
    assign div_prod = {12'd0, byte_offset} * {13'd0, DIV3_MUL};
    assign in_q     = div_prod[DIV3_SHIFT +: 12];
    assign in_rem   = byte_offset - 13'({in_q, 1'b0}) - 13'(in_q);

    assign in_cl_ok = {1'b0, cluster} < NUM_CL;
    assign in_ss_ok = {1'b0, cfg.search_start} < NUM_CL;
    assign in_b_ok  = {1'b0, byte_offset} < NUM_BYTES;
    assign cl_ok    = {1'b0, cl_reg} < NUM_CL;
    assign prev_ok  = {1'b0, prev_reg} < NUM_CL;
    assign scan_ok  = ({1'b0, scan_reg} < NUM_CL) && (scan_reg < EOC_MIN);
    assign scan_inc = scan_reg + 12'd1;
    assign scan_inc_ok = ({1'b0, scan_inc} < NUM_CL) && (scan_inc < EOC_MIN);

    assign cur_entry = entry_of(mem_rdata, (req_reg == REQ_ALLOC) ? scan_reg[0] : cl_reg[0]);
    assign cur_byte  = mem_rdata[8*blane_reg +: 8];

    // First sector of the cluster being reported; wraps modulo 2^32.
    assign sec_cl   = (req_reg == REQ_ALLOC) ? scan_reg : cl_reg;
    assign sec_base = {20'd0, sec_cl} - 32'd2;
    assign sector   = cfg.data_area_start + 32'(sec_base * cfg.sec_per_clus);

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        req_next     = req_reg;
        cl_next      = cl_reg;
        val_next     = val_reg;
        prev_next    = prev_reg;
        brow_next    = brow_reg;
        blane_next   = blane_reg;
        bok_next     = bok_reg;
        bval_next    = bval_reg;
        scan_next    = scan_reg;
        m_valid_next = m_valid_reg && !m_tready;
        res_next     = res_reg;
        s_tready     = 1'b0;
        mem_en       = 1'b0;
        mem_we       = 1'b0;
        mem_addr     = '0;
        mem_wdata    = '0;

        case (state_reg)
            ST_CLEAR: begin
                mem_en       = 1'b1;
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ROW) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    req_next   = req_type;
                    cl_next    = cluster;
                    val_next   = entry_value;
                    prev_next  = chain_tail;
                    brow_next  = in_b_ok ? ROW_W'(in_q) : '0;
                    blane_next = in_rem[1:0];
                    bok_next   = in_b_ok;
                    bval_next  = byte_value;
                    scan_next  = cfg.search_start;
                    mem_en     = 1'b1;
                    case (req_type)
                        REQ_READ_ENTRY,
                        REQ_WRITE_ENTRY: mem_addr = in_cl_ok ? row_of(cluster) : '0;
                        REQ_ALLOC:       mem_addr = in_ss_ok ? row_of(cfg.search_start) : '0;
                        REQ_WRITE_BYTE,
                        REQ_READ_BYTE:   mem_addr = in_b_ok ? ROW_W'(in_q) : '0;
                        default:         mem_addr = '0;
                    endcase
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                if (out_free) begin
                    res_next = '0;
                    case (req_reg)
                        REQ_READ_ENTRY: begin
                            res_next.result_cluster = cl_reg;
                            res_next.result_value   = cl_ok ? cur_entry : '0;
                            res_next.first_sector   = sector;
                            res_next.end_of_chain   = cl_ok && (cur_entry >= EOC_MIN);
                            m_valid_next = 1'b1;
                            state_next   = ST_IDLE;
                        end
                        REQ_WRITE_ENTRY: begin
                            mem_en    = cl_ok;
                            mem_we    = cl_ok;
                            mem_addr  = cl_ok ? row_of(cl_reg) : '0;
                            mem_wdata = row_with_entry(mem_rdata, cl_reg[0], val_reg);
                            res_next.result_cluster = cl_reg;
                            res_next.first_sector   = sector;
                            m_valid_next = 1'b1;
                            state_next   = ST_IDLE;
                        end
                        REQ_ALLOC: begin
                            if (!scan_ok) begin
                                res_next.status = 1'b1;
                                m_valid_next    = 1'b1;
                                state_next      = ST_IDLE;
                            end else if (cur_entry == '0) begin
                                // Mark the free entry as end of chain.
                                mem_en    = 1'b1;
                                mem_we    = 1'b1;
                                mem_addr  = row_of(scan_reg);
                                mem_wdata = row_with_entry(mem_rdata, scan_reg[0], EOC_MARK);
                                if (prev_reg != '0 && prev_ok) begin
                                    m_valid_next = m_valid_reg && !m_tready;
                                    res_next     = res_reg;
                                    state_next   = ST_LINK_RD;
                                end else begin
                                    res_next.result_cluster = scan_reg;
                                    res_next.first_sector   = sector;
                                    m_valid_next = 1'b1;
                                    state_next   = ST_IDLE;
                                end
                            end else begin
                                // Entry in use: read the row of the next cluster.
                                m_valid_next = m_valid_reg && !m_tready;
                                res_next     = res_reg;
                                scan_next    = scan_inc;
                                mem_en       = 1'b1;
                                mem_addr     = scan_inc_ok ? row_of(scan_inc) : '0;
                            end
                        end
                        REQ_WRITE_BYTE: begin
                            mem_en    = bok_reg;
                            mem_we    = bok_reg;
                            mem_addr  = brow_reg;
                            mem_wdata = mem_rdata;
                            mem_wdata[8*blane_reg +: 8] = bval_reg;
                            m_valid_next = 1'b1;
                            state_next   = ST_IDLE;
                        end
                        REQ_READ_BYTE: begin
                            res_next.result_value = bok_reg ? {4'd0, cur_byte} : '0;
                            m_valid_next = 1'b1;
                            state_next   = ST_IDLE;
                        end
                        default: begin
                            m_valid_next = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_LINK_RD: begin
                mem_en     = 1'b1;
                mem_addr   = row_of(prev_reg);
                state_next = ST_LINK_WR;
            end

            ST_LINK_WR: begin
                if (out_free) begin
                    mem_en    = 1'b1;
                    mem_we    = 1'b1;
                    mem_addr  = row_of(prev_reg);
                    mem_wdata = row_with_entry(mem_rdata, prev_reg[0], scan_reg);
                    res_next  = '0;
                    res_next.result_cluster = scan_reg;
                    res_next.first_sector   = sector;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        cl_reg    <= cl_next;
        val_reg   <= val_next;
        prev_reg  <= prev_next;
        brow_reg  <= brow_next;
        blane_reg <= blane_next;
        bok_reg   <= bok_next;
        bval_reg  <= bval_next;
        scan_reg  <= scan_next;
        res_reg   <= res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign result   = res_reg;

endmodule

// File: rtl/fat12_cluster_table_engine.sv
// ----------------------------------------------------------------------------
// FAT12 cluster table engine
// Holds a packed FAT12 allocation table and serves entry, byte and allocate
// requests over a stream interface with an APB-style configuration port.
// ----------------------------------------------------------------------------
// The table lives in one single-port synchronous memory of
// (NUM_CLUSTERS + 1) / 2 rows (2048 at the default size), each row holding
// the three image bytes of an even/odd cluster pair. After reset the engine
// runs a clearing pass that zeroes one row per cycle, and s_tready stays low
// until it is done; configuration writes are taken throughout. For entry
// reads and writes, byte reads and writes and unused request codes, the row
// is read when the request is accepted and is checked, modified and written
// back in the execute state once the output register is free. An allocate
// request gives each cluster examined by the scan its own read of the memory
// port, and when a previous cluster is linked to the new one it adds a read
// and a write of that cluster's row. When the scan runs out of clusters it
// reports that no cluster is free. A finished result sits in an output
// register, so the next request is accepted while it waits on m_tready.
// Each request returns exactly one result.
// ----------------------------------------------------------------------------
module fat12_cluster_table_engine #(
    parameter int NUM_CLUSTERS = 4096
) (
    input  logic         aclk,
    input  logic         aresetn,

    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,

    // Request channel.
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: cluster[11:0], entry_value[23:12], chain_tail[35:24],
    //        byte_offset[48:36], byte_value[56:49], zero[63:57]
    input  logic [63:0]  s_tdata,
    // tuser: req_type[2:0]
    input  logic [2:0]   s_tuser,

    // Result channel.
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: result_cluster[11:0], result_value[23:12], first_sector[55:24],
    //        end_of_chain[56], zero[63:57]
    output logic [63:0]  m_tdata,
    // tuser: status[0]
    output logic [0:0]   m_tuser
);
    import fat12cte_pkg::*;

    localparam int ROWS  = (NUM_CLUSTERS + 1) / 2;
    localparam int ROW_W = $clog2(ROWS);

    cfg_t                 cfg;
    result_t              result;
    logic                 mem_en;
    logic                 mem_we;
    logic [ROW_W-1:0]     mem_addr;
    logic [ROW_BITS-1:0]  mem_wdata;
    logic [ROW_BITS-1:0]  mem_rdata;

    fat12cte_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fat12cte_ram #(
        .DEPTH  (ROWS),
        .ADDR_W (ROW_W)
    ) u_ram (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    fat12cte_seq #(
        .NUM_CLUSTERS (NUM_CLUSTERS),
        .ROWS         (ROWS),
        .ROW_W        (ROW_W)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .req_type     (s_tuser),
        .cluster      (s_tdata[11:0]),
        .entry_value  (s_tdata[23:12]),
        .chain_tail   (s_tdata[35:24]),
        .byte_offset  (s_tdata[48:36]),
        .byte_value   (s_tdata[56:49]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .result       (result),
        .mem_en       (mem_en),
        .mem_we       (mem_we),
        .mem_addr     (mem_addr),
        .mem_wdata    (mem_wdata),
        .mem_rdata    (mem_rdata)
    );

    // Result packing, lowest field in the lowest bits.
    assign m_tdata = {7'd0, result.end_of_chain, result.first_sector,
                      result.result_value, result.result_cluster};
    assign m_tuser = result.status;

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// FAT12 cluster table engine testbench
// Drives entry, byte, allocate and unused requests into the engine over its
// request stream, programs the three configuration registers between phases,
// and checks every result against a behavioral model of the packed table.
// ----------------------------------------------------------------------------
module tb_top;
    import fat12cte_pkg::*;

    localparam int CLUSTERS       = 4096;
    localparam int IMAGE_BYTES    = (3 * CLUSTERS + 1) / 2;
    localparam int PHASES         = 6;
    localparam int ITEMS_PER_PHASE = 305;
    localparam int SETTLE_CYCLES  = 16;
    localparam int SQUEEZE_CYCLES = 300;

    // Request codes the engine does not define; they must produce a zero result.
    localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

    // One request as the engine sees it, before packing onto the stream.
    typedef struct {
        logic [2:0]  kind;
        logic [11:0] cluster;
        logic [11:0] value;
        logic [11:0] prev;
        logic [12:0] offset;
        logic [7:0]  data;
    } fat_req_t;

    // ------------------------------------------------------------------------
    // Scoreboard: a copy of the table image and registers, plus the queue of
    // results the engine still owes us, oldest first.
    // ------------------------------------------------------------------------
    class fat_table_model;
        logic [7:0]  image [IMAGE_BYTES];
        logic [7:0]  spc;
        logic [31:0] data_start;
        logic [11:0] search_from;
        logic [11:0] last_found;
        result_t     results_due [$];
        int unsigned errors;
        int unsigned seen;

        function new();
            foreach (image[i]) image[i] = 8'h00;
            spc         = SPC_RESET;
            data_start  = DATA_START_RESET;
            search_from = SEARCH_START_RESET;
            last_found  = '0;
            errors      = 0;
            seen        = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_SPC:          spc = val[7:0];
                REG_DATA_START:   data_start = val;
                REG_SEARCH_START: search_from = val[11:0];
                default: ;
            endcase
        endfunction

        function logic [11:0] entry_get(logic [11:0] c);
            int unsigned off;
            logic [15:0] w;
            off = c;
            off = off * 3 / 2;
            w = {image[off + 1], image[off]};
            return c[0] ? w[15:4] : w[11:0];
        endfunction

        function void entry_set(logic [11:0] c, logic [11:0] v);
            int unsigned off;
            off = c;
            off = off * 3 / 2;
            if (c[0]) begin
                image[off]     = {v[3:0], image[off][3:0]};
                image[off + 1] = v[11:4];
            end else begin
                image[off]     = v[7:0];
                image[off + 1] = {image[off + 1][7:4], v[11:8]};
            end
        endfunction

        function logic [31:0] sector_of(logic [11:0] c);
            logic [31:0] cw;
            cw = {20'd0, c};
            return data_start + (cw - 32'd2) * {24'd0, spc};
        endfunction

        // First free cluster the allocate scan would land on, or -1 if none.
        function int find_free();
            for (int unsigned c = search_from; c < EOC_MIN && c < CLUSTERS; c++) begin
                if (entry_get(12'(c)) == 12'h000) return c;
            end
            return -1;
        endfunction

        function int unsigned pending();
            return results_due.size();
        endfunction

        // Applies an accepted request to the model and queues its result.
        function void note_request(fat_req_t r);
            result_t e;
            int slot;
            e = '0;
            case (r.kind)
                REQ_READ_ENTRY: begin
                    e.result_cluster = r.cluster;
                    e.result_value   = entry_get(r.cluster);
                    e.first_sector   = sector_of(r.cluster);
                    e.end_of_chain   = (e.result_value >= EOC_MIN);
                end
                REQ_WRITE_ENTRY: begin
                    entry_set(r.cluster, r.value);
                    e.result_cluster = r.cluster;
                    e.first_sector   = sector_of(r.cluster);
                end
                REQ_ALLOC: begin
                    slot = find_free();
                    if (slot < 0) begin
                        e.status = 1'b1;
                    end else begin
                        // Mark first, then link: a self link overwrites the mark.
                        entry_set(12'(slot), EOC_MARK);
                        if (r.prev != 12'h000) entry_set(r.prev, 12'(slot));
                        last_found       = 12'(slot);
                        e.result_cluster = 12'(slot);
                        e.first_sector   = sector_of(12'(slot));
                    end
                end
                REQ_WRITE_BYTE: begin
                    if (r.offset < IMAGE_BYTES) image[r.offset] = r.data;
                end
                REQ_READ_BYTE: begin
                    if (r.offset < IMAGE_BYTES) e.result_value = {4'h0, image[r.offset]};
                end
                default: ;
            endcase
            results_due.push_back(e);
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] result %0d mismatch: %s", $time, seen, what);
        endtask

        task compare(string field, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %h, expected %h", field, got, want));
        endtask

        task check_result(logic [63:0] data, logic [0:0] user);
            result_t e;
            seen++;
            if (results_due.size() == 0) begin
                report($sformatf("unrequested result tdata %h tuser %h", data, user));
                return;
            end
            e = results_due.pop_front();
            compare("result_cluster", {20'd0, data[11:0]}, {20'd0, e.result_cluster});
            compare("result_value", {20'd0, data[23:12]}, {20'd0, e.result_value});
            compare("first_sector", data[55:24], e.first_sector);
            compare("end_of_chain", {31'd0, data[56]}, {31'd0, e.end_of_chain});
            compare("status", {31'd0, user[0]}, {31'd0, e.status});
            compare("tdata padding", {25'd0, data[63:57]}, 32'd0);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the signals we drive. Everything starts at a known value.
    // ------------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;

    // calm turns off idling on both sides; squeeze asks the result side for
    // one long hold-off.
    bit calm    = 1'b0;
    bit squeeze = 1'b0;

    fat_table_model sb = new();

    always #5 aclk = ~aclk;

    fat12_cluster_table_engine u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // A cluster close above the scan start, where allocations and entry
    // writes collide most often.
    function automatic logic [11:0] near_search();
        int unsigned c;
        c = sb.search_from + $urandom_range(300);
        return (c > CLUSTERS - 1) ? 12'(CLUSTERS - 1) : 12'(c);
    endfunction

    function automatic fat_req_t mk(logic [2:0] kind, logic [11:0] cluster,
                                    logic [11:0] value, logic [11:0] prev,
                                    logic [12:0] offset, logic [7:0] data);
        fat_req_t r;
        r.kind    = kind;
        r.cluster = cluster;
        r.value   = value;
        r.prev    = prev;
        r.offset  = offset;
        r.data    = data;
        return r;
    endfunction

    // Random request. Every field starts fully random so all bits toggle, then
    // the fields that matter for the chosen kind are steered toward cases that
    // exercise chains, end-of-chain values and the image boundary.
    function automatic fat_req_t random_req();
        fat_req_t r;
        int unsigned pick;
        int slot;
        r = mk(3'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
               13'($urandom), 8'($urandom));
        pick = $urandom_range(99);
        if (pick < 22) begin
            r.kind = REQ_READ_ENTRY;
            if ($urandom_range(1) == 1) r.cluster = near_search();
        end else if (pick < 40) begin
            r.kind = REQ_WRITE_ENTRY;
            if ($urandom_range(9) < 4) r.cluster = near_search();
            pick = $urandom_range(99);
            if (pick < 10) r.value = '0;
            else if (pick < 25) r.value = 12'($urandom_range(4095, EOC_MIN));
        end else if (pick < 62) begin
            r.kind = REQ_ALLOC;
            pick = $urandom_range(99);
            if (pick < 45) begin
                r.prev = sb.last_found;
            end else if (pick < 60) begin
                r.prev = '0;
            end else if (pick < 70) begin
                slot = sb.find_free();
                if (slot >= 0) r.prev = 12'(slot);
            end
        end else if (pick < 94) begin
            r.kind = (pick < 74) ? REQ_WRITE_BYTE : REQ_READ_BYTE;
            if ($urandom_range(99) < 85) r.offset = 13'($urandom_range(IMAGE_BYTES - 1));
        end else begin
            r.kind = 3'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST));
        end
        return r;
    endfunction

    // APB write: setup cycle, then access cycle until pready. The model is
    // updated at the same point, which is safe because the engine is idle.
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // Offers one request and returns once it is accepted. tvalid is left high
    // so the next call can present its request without a bubble; drain()
    // lowers it.
    task automatic send_req(input fat_req_t r);
        int unsigned gap;
        gap = calm ? 0 : pick_gap();
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, r.data, r.offset, r.prev, r.value, r.cluster};
        s_tuser  <= r.kind;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(r);
    endtask

    // Stops offering and waits until every result is back, then waits out the
    // settling period so a trailing link write inside the engine has finished.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Result side. Before each result it picks a stall; when squeeze is set it
    // holds tready low for a long stretch so the engine's output register
    // fills and the request side backs up.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned hold;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (squeeze) begin
                hold    = SQUEEZE_CYCLES;
                squeeze = 1'b0;
            end else begin
                hold = calm ? 0 : pick_gap();
            end
            if (hold != 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata, m_tuser);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus. A directed pass under the reset register values covers the
    // field extremes, end-of-chain values, the last image byte, offsets past
    // the image, chained allocation, a self link and the unused codes. Then
    // random phases, each with its own register setting: the extremes first,
    // then scan starts near the top of the range where the allocator runs out
    // of free clusters, then random settings.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0]  spc_v;
        logic [31:0] start_v;
        logic [11:0] from_v;
        int slot;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // The engine clears its table after reset; send_req simply waits for
        // tready, so the first request also proves the clearing finished.
        send_req(mk(REQ_READ_ENTRY, 12'h000, 12'h000, 12'h000, 13'h0000, 8'h00));
        send_req(mk(REQ_READ_ENTRY, 12'hFFF, 12'hFFF, 12'hFFF, 13'h1FFF, 8'hFF));
        send_req(mk(REQ_WRITE_ENTRY, 12'h000, EOC_MARK, 12'h000, 13'h0000, 8'h00));
        send_req(mk(REQ_READ_ENTRY, 12'h000, 12'h000, 12'h000, 13'h0000, 8'h00));
        send_req(mk(REQ_WRITE_ENTRY, 12'h001, EOC_MIN, 12'h000, 13'h0000, 8'h00));
        send_req(mk(REQ_READ_ENTRY, 12'h001, 12'h000, 12'h000, 13'h0000, 8'h00));
        send_req(mk(REQ_WRITE_ENTRY, 12'h001, EOC_MIN - 12'h001, 12'h000, 13'h0, 8'h00));
        send_req(mk(REQ_READ_ENTRY, 12'h001, 12'h000, 12'h000, 13'h0000, 8'h00));
        send_req(mk(REQ_WRITE_ENTRY, 12'hFFF, 12'h8A5, 12'h000, 13'h0000, 8'h00));
        send_req(mk(REQ_READ_ENTRY, 12'hFFF, 12'h000, 12'h000, 13'h0000, 8'h00));
        // Last byte of the image holds the top of the odd entry just written.
        send_req(mk(REQ_READ_BYTE, 12'h000, 12'h000, 12'h000, 13'(IMAGE_BYTES - 1), 8'h00));
        send_req(mk(REQ_WRITE_BYTE, 12'h000, 12'h000, 12'h000, 13'(IMAGE_BYTES - 1), 8'hFF));
        send_req(mk(REQ_READ_ENTRY, 12'hFFF, 12'h000, 12'h000, 13'h0000, 8'h00));
        // Offsets past the image: the write is dropped, the read returns zero.
        send_req(mk(REQ_WRITE_BYTE, 12'h000, 12'h000, 12'h000, 13'(IMAGE_BYTES), 8'h5A));
        send_req(mk(REQ_READ_BYTE, 12'h000, 12'h000, 12'h000, 13'h1FFF, 8'h00));
        send_req(mk(REQ_READ_BYTE, 12'h000, 12'h000, 12'h000, 13'h0000, 8'h00));
        // Allocation: no link, a chain link, a self link, a link at the top.
        send_req(mk(REQ_ALLOC, 12'h000, 12'h000, 12'h000, 13'h0000, 8'h00));
        send_req(mk(REQ_ALLOC, 12'h000, 12'h000, sb.last_found, 13'h0000, 8'h00));
        slot = sb.find_free();
        send_req(mk(REQ_ALLOC, 12'h000, 12'h000, 12'(slot), 13'h0000, 8'h00));
        send_req(mk(REQ_ALLOC, 12'h000, 12'h000, 12'hFFF, 13'h0000, 8'h00));
        send_req(mk(REQ_READ_ENTRY, SEARCH_START_RESET, 12'h000, 12'h000, 13'h0, 8'h00));
        send_req(mk(REQ_READ_ENTRY, 12'(slot), 12'h000, 12'h000, 13'h0000, 8'h00));
        for (int k = REQ_SPARE_FIRST; k <= REQ_SPARE_LAST; k++)
            send_req(mk(3'(k), 12'hFFF, 12'hFFF, 12'hFFF, 13'h1FFF, 8'hFF));
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    spc_v = 8'd128; start_v = 32'hFFFF_FFFF; from_v = 12'd2;
                end
                1: begin
                    spc_v = 8'd1; start_v = 32'h0000_0000; from_v = EOC_MIN - 12'd1;
                end
                2: begin
                    spc_v = 8'($urandom_range(128, 1)); start_v = $urandom;
                    from_v = EOC_MIN - 12'd16;
                end
                default: begin
                    spc_v = 8'($urandom_range(128, 1)); start_v = $urandom;
                    from_v = 12'($urandom_range(EOC_MIN - 1, 2));
                end
            endcase
            cfg_write(REG_SPC, {24'd0, spc_v});
            cfg_write(REG_DATA_START, start_v);
            cfg_write(REG_SEARCH_START, {20'd0, from_v});

            // One phase runs with no idling at all, another opens with the
            // long hold-off on the result side while requests keep coming.
            calm    = (p == 2);
            squeeze = (p == 3);
            repeat (ITEMS_PER_PHASE) send_req(random_req());
            drain();
        end

        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog. Sized from the slowest legal run: every request an allocate
    // scanning the whole table, plus the longest gaps on both sides and the
    // clearing pass, taken several times over.
    initial begin : watchdog
        #400_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/fat12cte_pkg.sv
rtl/fat12cte_ram.sv
rtl/fat12cte_regs.sv
rtl/fat12cte_seq.sv
rtl/fat12_cluster_table_engine.sv
tb/sv/tb_top.sv
